>>> sv/lfps_pkg.sv
// Shared types, constants and helper functions of the line-follower steering block.
`default_nettype none

package lfps_pkg;

    // Integral accumulator width (signed), product and datapath widths
    localparam int INTEGRAL_WIDTH = 32;
    localparam int Q_FRAC         = 24;
    localparam int TERM_SHIFT     = 40;
    localparam int CORR_W         = 44;
    localparam int V_W            = 46;

    // Stream payload widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fixed wheel speeds
    localparam logic [7:0] SPD_FAST   = 8'd85;
    localparam logic [7:0] SPD_NORMAL = 8'd80;
    localparam logic [7:0] SPD_SLOW   = 8'd75;
    localparam logic [7:0] SPD_STOP   = 8'd65;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P        = 3'd0,
        CFG_GAIN_I        = 3'd1,
        CFG_GAIN_D        = 3'd2,
        CFG_CRUISE_SPD    = 3'd3,
        CFG_TOP_SPD       = 3'd4,
        CFG_FLOOR_SPD     = 3'd5,
        CFG_TIMEOUT_MS    = 3'd6,
        CFG_STOP_DISTANCE = 3'd7
    } cfg_idx_t;

    // Configuration register file contents
    typedef struct packed {
        logic [31:0] gain_p;
        logic [31:0] gain_i;
        logic [31:0] gain_d;
        logic [7:0]  cruise_spd;
        logic [7:0]  top_spd;
        logic [7:0]  floor_spd;
        logic [15:0] timeout_ms;
        logic [9:0]  stop_distance;
    } cfg_t;

    // Recovery speed pair
    typedef struct packed {
        logic [7:0] right;
        logic [7:0] left;
    } speed_pair_t;

    // Weighted sum of sensors that see the line (bit low), weights -2..2
    function automatic logic signed [2:0] weight_sum(input logic [4:0] bits);
        logic signed [3:0] acc;
        acc = 4'sd0;
        for (int i = 0; i < 5; i++) begin
            if (!bits[i]) begin
                acc = acc + 4'(signed'(i - 2));
            end
        end
        return acc[2:0];
    endfunction

    // Recovery pair chosen by the last seen direction
    function automatic speed_pair_t recovery_pair(input logic signed [2:0] dir);
        speed_pair_t p;
        case (dir)
            3'sd3:   p = '{right: SPD_FAST,   left: SPD_SLOW};
            3'sd2:   p = '{right: SPD_NORMAL, left: SPD_STOP};
            3'sd1:   p = '{right: SPD_NORMAL, left: SPD_SLOW};
            3'sd0:   p = '{right: SPD_SLOW,   left: SPD_SLOW};
            -3'sd1:  p = '{right: SPD_SLOW,   left: SPD_NORMAL};
            -3'sd2:  p = '{right: SPD_STOP,   left: SPD_NORMAL};
            default: p = '{right: SPD_SLOW,   left: SPD_FAST};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> sv/lfps_cfg.sv
// Configuration register file of the line-follower steering block.
`default_nettype none

module lfps_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfps_pkg::CFG_DATA_W-1:0] cfg_data,
    output lfps_pkg::cfg_t                  cfg
);
    import lfps_pkg::*;

    cfg_t cfg_reg;

    // Register writes, reset to the default tuning
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p        <= 32'd83886080;
            cfg_reg.gain_i        <= 32'd12;
            cfg_reg.gain_d        <= 32'd822083584;
            cfg_reg.cruise_spd    <= SPD_SLOW;
            cfg_reg.top_spd       <= SPD_FAST;
            cfg_reg.floor_spd     <= SPD_STOP;
            cfg_reg.timeout_ms    <= 16'd3000;
            cfg_reg.stop_distance <= 10'd7;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P:        cfg_reg.gain_p        <= cfg_data;
                CFG_GAIN_I:        cfg_reg.gain_i        <= cfg_data;
                CFG_GAIN_D:        cfg_reg.gain_d        <= cfg_data;
                CFG_CRUISE_SPD:    cfg_reg.cruise_spd    <= cfg_data[7:0];
                CFG_TOP_SPD:       cfg_reg.top_spd       <= cfg_data[7:0];
                CFG_FLOOR_SPD:     cfg_reg.floor_spd     <= cfg_data[7:0];
                CFG_TIMEOUT_MS:    cfg_reg.timeout_ms    <= cfg_data[15:0];
                CFG_STOP_DISTANCE: cfg_reg.stop_distance <= cfg_data[9:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/lfps_pid.sv
// Fixed-point PID correction and wheel speed clamp of the steering block.
`default_nettype none

module lfps_pid (
    input  lfps_pkg::cfg_t                              cfg,
    input  logic signed [2:0]                           err,
    input  logic signed [3:0]                           last_error,
    input  logic signed [lfps_pkg::INTEGRAL_WIDTH-1:0]  integral,
    output logic signed [lfps_pkg::INTEGRAL_WIDTH-1:0]  integral_next,
    output logic [7:0]                                  speed_left,
    output logic [7:0]                                  speed_right
);
    import lfps_pkg::*;

    localparam int IW = INTEGRAL_WIDTH;
    localparam int PW = IW + 33;

    localparam logic signed [IW:0] IMAX = {2'b00, {(IW-1){1'b1}}};
    localparam logic signed [IW:0] IMIN = {2'b11, {(IW-1){1'b0}}};
    localparam logic signed [PW-1:0] TERM_POS =
        {{(PW-TERM_SHIFT-1){1'b0}}, 1'b1, {TERM_SHIFT{1'b0}}};
    localparam logic signed [PW-1:0] TERM_NEG = -TERM_POS;

    logic signed [IW:0]       isum;
    logic signed [IW:0]       isat;
    logic signed [4:0]        derr;
    logic signed [32:0]       gp_s;
    logic signed [32:0]       gi_s;
    logic signed [32:0]       gd_s;
    logic signed [35:0]       p_term;
    logic signed [PW-1:0]     i_prod;
    logic signed [CORR_W-1:0] i_term;
    logic signed [37:0]       d_term;
    logic signed [CORR_W-1:0] corr;
    logic signed [V_W-1:0]    base_v;
    logic signed [V_W-1:0]    lo_v;
    logic signed [V_W-1:0]    hi_v;
    logic signed [V_W-1:0]    v_left;
    logic signed [V_W-1:0]    v_right;

    // Saturating integral update
    always_comb
    begin
        isum = (IW+1)'(integral) + (IW+1)'(err);
        if (isum > IMAX)
        begin
            isat = IMAX;
        end
        else if (isum < IMIN)
        begin
            isat = IMIN;
        end
        else
        begin
            isat = isum;
        end
    end

    assign integral_next = isat[IW-1:0];

    // Three gain products; the integral term saturates at +-2^40
    assign gp_s   = $signed({1'b0, cfg.gain_p});
    assign gi_s   = $signed({1'b0, cfg.gain_i});
    assign gd_s   = $signed({1'b0, cfg.gain_d});
    assign derr   = 5'(err) - 5'(last_error);
    assign p_term = gp_s * err;
    assign i_prod = gi_s * integral_next;
    assign d_term = gd_s * derr;

    always_comb
    begin
        if (i_prod > TERM_POS)
        begin
            i_term = CORR_W'(TERM_POS);
        end
        else if (i_prod < TERM_NEG)
        begin
            i_term = CORR_W'(TERM_NEG);
        end
        else
        begin
            i_term = CORR_W'(i_prod);
        end
    end

    assign corr = CORR_W'(p_term) + i_term + CORR_W'(d_term);

    // Speeds in Q.24 around the base speed
    assign base_v  = $signed({{(V_W-8-Q_FRAC){1'b0}}, cfg.cruise_spd, {Q_FRAC{1'b0}}});
    assign lo_v    = $signed({{(V_W-8-Q_FRAC){1'b0}}, cfg.floor_spd, {Q_FRAC{1'b0}}});
    assign hi_v    = $signed({{(V_W-8-Q_FRAC){1'b0}}, cfg.top_spd, {Q_FRAC{1'b0}}});
    assign v_left  = base_v + V_W'(corr);
    assign v_right = base_v - V_W'(corr);

    // Clamp: the lower bound wins when both fire
    function automatic logic [7:0] clamp_speed(
        input logic signed [V_W-1:0] v,
        input logic signed [V_W-1:0] lo,
        input logic signed [V_W-1:0] hi,
        input logic [7:0]            min_s,
        input logic [7:0]            max_s
    );
        logic [7:0] r;
        if (v < lo)
        begin
            r = min_s;
        end
        else if (v > hi)
        begin
            r = max_s;
        end
        else
        begin
            r = v[Q_FRAC+7:Q_FRAC];
        end
        return r;
    endfunction

    assign speed_left  = clamp_speed(v_left, lo_v, hi_v, cfg.floor_spd, cfg.top_spd);
    assign speed_right = clamp_speed(v_right, lo_v, hi_v, cfg.floor_spd, cfg.top_spd);

endmodule

`default_nettype wire

>>> sv/line_follower_pid_steering.sv
// Top level of the line-follower PID steering controller.
// Usage:
//   Input stream s_*: one beat per control step carrying the five line
//   sensors (0 = line seen), the obstacle distance and a ms timestamp.
//   Output stream m_*: one beat per input beat with both wheel speeds,
//   the table position and the lift-off flag, in input order.
//   Config port: cfg_we/cfg_index/cfg_data writes one register per cycle;
//   write only while no beat is in flight.
// Timing:
//   An input beat lands in an input register; the step (three gain
//   products, integral saturation, clamp, mode select) is combinational
//   from there into the state registers, which drive m_tdata directly.
//   m_tvalid rises when the step is written into the state registers,
//   after the input register; one beat per cycle is sustained while
//   m_tready stays high, as the PID step closes the state loop combinationally.
// Reset: rst_n clears the state (integral, timers, counters) and sets both
//   wheels to stop speed; the config registers return to default tuning.
// Stall: while m_tready is low the result holds, one more beat waits in
//   the input register, and s_tready drops after that.
`default_nettype none

module line_follower_pid_steering (
    input  logic                             clk,
    input  logic                             rst_n,
    // sensor_bits[4:0], distance_cm[14:5], now_ms[46:15], zero pad
    input  logic [lfps_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // speed_left[7:0], speed_right[15:8], table_position[18:16], halted[19], zero pad
    output logic [lfps_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lfps_pkg::*;

    localparam int IW = INTEGRAL_WIDTH;

    cfg_t cfg;

    // Input stage
    logic        in_valid_reg;
    logic [4:0]  sensor_reg;
    logic [9:0]  dist_reg;
    logic [31:0] now_reg;
    logic        out_valid_reg;
    logic        advance;

    // Controller state
    logic signed [IW-1:0] integral_reg, integral_next;
    logic signed [3:0]    last_error_reg, last_error_next;
    logic signed [2:0]    last_dir_reg, last_dir_next;
    logic [2:0]           table_count_reg, table_count_next;
    logic                 latched_reg, latched_next;
    logic                 lifted_reg, lifted_next;
    logic [31:0]          on_line_time_reg, on_line_time_next;
    logic [31:0]          partial_time_reg, partial_time_next;
    logic [7:0]           left_speed_reg, left_speed_next;
    logic [7:0]           right_speed_reg, right_speed_next;

    // Step datapath
    logic signed [2:0]    err;
    logic signed [IW-1:0] pid_integral;
    logic [7:0]           pid_left;
    logic [7:0]           pid_right;
    logic                 obstacle;
    logic                 all_on;
    logic                 all_off;
    logic [31:0]          elapsed_partial;
    logic [31:0]          elapsed_on_line;
    logic                 partial_expired;
    logic                 on_line_expired;
    speed_pair_t          rec;

    lfps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfps_pid u_pid (
        .cfg           (cfg),
        .err           (err),
        .last_error    (last_error_reg),
        .integral      (integral_reg),
        .integral_next (pid_integral),
        .speed_left    (pid_left),
        .speed_right   (pid_right)
    );

    // Handshake: step runs when the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, lifted_reg, table_count_reg, right_speed_reg, left_speed_reg};

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sensor_reg <= s_tdata[4:0];
            dist_reg   <= s_tdata[14:5];
            now_reg    <= s_tdata[46:15];
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Step decode
    assign err             = weight_sum(sensor_reg);
    assign obstacle        = dist_reg < cfg.stop_distance;
    assign all_on          = ~|sensor_reg;
    assign all_off         = &sensor_reg;
    assign elapsed_partial = now_reg - partial_time_reg;
    assign elapsed_on_line = now_reg - on_line_time_reg;
    assign partial_expired = elapsed_partial >= {16'd0, cfg.timeout_ms};
    assign on_line_expired = elapsed_on_line >= {16'd0, cfg.timeout_ms};
    assign rec             = recovery_pair(last_dir_reg);

    // Mode select and next state
    always_comb
    begin
        integral_next     = integral_reg;
        last_error_next   = last_error_reg;
        last_dir_next     = last_dir_reg;
        table_count_next  = table_count_reg;
        latched_next      = latched_reg;
        lifted_next       = lifted_reg;
        on_line_time_next = on_line_time_reg;
        partial_time_next = partial_time_reg;
        left_speed_next   = left_speed_reg;
        right_speed_next  = right_speed_reg;
        if (obstacle)
        begin
            left_speed_next  = SPD_STOP;
            right_speed_next = SPD_STOP;
        end
        else
        begin
            // full-line mark: debounced table count, lift-off check
            if (all_on)
            begin
                if (!latched_reg)
                begin
                    table_count_next = (table_count_reg == 3'd6) ? 3'd0 : table_count_reg + 3'd1;
                    latched_next     = 1'b1;
                end
                if (partial_expired)
                begin
                    lifted_next      = 1'b1;
                    left_speed_next  = SPD_STOP;
                    right_speed_next = SPD_STOP;
                end
            end
            else
            begin
                partial_time_next = now_reg;
                latched_next      = 1'b0;
                lifted_next       = 1'b0;
            end
            // line lost: recovery pair until timeout, then stop; else PID unless lifted
            if (all_off)
            begin
                if (on_line_expired)
                begin
                    last_dir_next    = 3'sd0;
                    left_speed_next  = SPD_STOP;
                    right_speed_next = SPD_STOP;
                end
                else
                begin
                    left_speed_next  = rec.left;
                    right_speed_next = rec.right;
                end
            end
            else if (!lifted_next)
            begin
                on_line_time_next = now_reg;
                last_dir_next     = err;
                integral_next     = pid_integral;
                last_error_next   = 4'(err);
                left_speed_next   = pid_left;
                right_speed_next  = pid_right;
            end
        end
    end

    // State registers, updated once per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg     <= '0;
            last_error_reg   <= 4'sd0;
            last_dir_reg     <= 3'sd0;
            table_count_reg  <= 3'd0;
            latched_reg      <= 1'b0;
            lifted_reg       <= 1'b0;
            on_line_time_reg <= 32'd0;
            partial_time_reg <= 32'd0;
            left_speed_reg   <= SPD_STOP;
            right_speed_reg  <= SPD_STOP;
        end
        else if (advance)
        begin
            integral_reg     <= integral_next;
            last_error_reg   <= last_error_next;
            last_dir_reg     <= last_dir_next;
            table_count_reg  <= table_count_next;
            latched_reg      <= latched_next;
            lifted_reg       <= lifted_next;
            on_line_time_reg <= on_line_time_next;
            partial_time_reg <= partial_time_next;
            left_speed_reg   <= left_speed_next;
            right_speed_reg  <= right_speed_next;
        end
    end

`ifndef SYNTHESIS
    // table position stays modulo 7
    a_table_range: assert property (@(posedge clk) disable iff (!rst_n)
        table_count_reg != 3'd7)
        else $error("table count out of range");

    // lift-off is only flagged on a latched full-line mark
    a_lift_latched: assert property (@(posedge clk) disable iff (!rst_n)
        lifted_reg |-> latched_reg)
        else $error("lifted without latched mark");

    // stored direction is a real sensor sum
    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        last_dir_reg != -3'sd4)
        else $error("last direction out of range");

    // state moves only when a step runs
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable({integral_reg, last_error_reg, table_count_reg,
                              left_speed_reg, right_speed_reg, lifted_reg}))
        else $error("state changed without a step");

    // input stage refuses beats only when full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a slot is free");
`endif

endmodule

`default_nettype wire

>>> verif/steering_checker.sv
// Checker for the steering block: predicts each control step's drive beat and compares it.
`timescale 1ns / 100ps

module steering_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    // sensor_bits[4:0], distance_cm[14:5], now_ms[46:15], zero pad
    input  logic [lfps_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // speed_left[7:0], speed_right[15:8], table_position[18:16], halted[19], zero pad
    input  logic [lfps_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               outstanding,
    output int                               compared
);
    import lfps_pkg::*;

    localparam longint unsigned TERM_CAP = 64'd1 << 40;
    localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic [2:0] table_pos;
        logic       halted;
    } drive_t;

    // Tuning copy
    logic [31:0] tune_gp, tune_gi, tune_gd;
    logic [7:0]  tune_base, tune_max, tune_min;
    logic [15:0] tune_timeout;
    logic [9:0]  tune_stop;

    // Controller copy
    logic signed [INTEGRAL_WIDTH-1:0] integ;
    int          prev_err;
    int          heading;
    logic [2:0]  marks;
    bit          mark_seen;
    bit          lifted;
    logic [31:0] t_on_line, t_partial;
    logic [7:0]  wheel_l, wheel_r;

    drive_t expected_drive[$];
    int     fails;
    int     checked;

    // Gain times signed operand, magnitude capped at 2^40
    function automatic longint gain_term(input logic [31:0] gain, input longint x);
        longint unsigned mag, prod;
        mag = (x < 0) ? -x : x;
        prod = mag * gain;
        if (prod > TERM_CAP) prod = TERM_CAP;
        return (x < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // Q.24 wheel value clamped to the tuning limits; min wins if both fire
    function automatic logic [7:0] clamp_wheel(input longint v);
        if (v < (longint'(tune_min) <<< 24)) return tune_min;
        if (v > (longint'(tune_max) <<< 24)) return tune_max;
        return v[31:24];
    endfunction

    task automatic steer_pid(input int err);
        longint acc, corr, base;
        acc = longint'(integ) + err;
        if (acc > INTEG_MAX) acc = INTEG_MAX;
        if (acc < INTEG_MIN) acc = INTEG_MIN;
        integ = acc[INTEGRAL_WIDTH-1:0];
        corr = gain_term(tune_gp, err) + gain_term(tune_gi, integ)
             + gain_term(tune_gd, err - prev_err);
        base = longint'(tune_base) <<< 24;
        wheel_l = clamp_wheel(base + corr);
        wheel_r = clamp_wheel(base - corr);
        prev_err = err;
    endtask

    // One control step of the controller
    task automatic advance_controller(input logic [4:0] bits, input logic [9:0] range_cm,
                                      input logic [31:0] now, output drive_t res);
        int          sum, off_cnt, i;
        logic [31:0] elapsed;
        if (range_cm < tune_stop) begin
            wheel_l = SPD_STOP;
            wheel_r = SPD_STOP;
        end
        else begin
            sum = 0;
            off_cnt = 0;
            for (i = 0; i < 5; i++) begin
                if (bits[i]) off_cnt++;
                else sum += i - 2;
            end
            // full-line mark: debounced count, lift-off check
            if (off_cnt == 0) begin
                if (!mark_seen) begin
                    marks = (marks == 3'd6) ? 3'd0 : marks + 3'd1;
                    mark_seen = 1'b1;
                end
                elapsed = now - t_partial;
                if (elapsed >= tune_timeout) begin
                    lifted = 1'b1;
                    wheel_l = SPD_STOP;
                    wheel_r = SPD_STOP;
                end
            end
            else begin
                t_partial = now;
                mark_seen = 1'b0;
                lifted = 1'b0;
            end
            if (off_cnt == 5) begin
                // line lost: recovery pair until timeout
                elapsed = now - t_on_line;
                if (elapsed >= tune_timeout) begin
                    heading = 0;
                    wheel_l = SPD_STOP;
                    wheel_r = SPD_STOP;
                end
                else begin
                    case (heading)
                        3:       begin wheel_l = SPD_SLOW;   wheel_r = SPD_FAST;   end
                        2:       begin wheel_l = SPD_STOP;   wheel_r = SPD_NORMAL; end
                        1:       begin wheel_l = SPD_SLOW;   wheel_r = SPD_NORMAL; end
                        0:       begin wheel_l = SPD_SLOW;   wheel_r = SPD_SLOW;   end
                        -1:      begin wheel_l = SPD_NORMAL; wheel_r = SPD_SLOW;   end
                        -2:      begin wheel_l = SPD_NORMAL; wheel_r = SPD_STOP;   end
                        default: begin wheel_l = SPD_FAST;   wheel_r = SPD_SLOW;   end
                    endcase
                end
            end
            else if (!lifted) begin
                t_on_line = now;
                heading = sum;
                steer_pid(sum);
            end
        end
        res.left = wheel_l;
        res.right = wheel_r;
        res.table_pos = marks;
        res.halted = lifted;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        drive_t want, next_drive;
        if (!rst_n) begin
            tune_gp = 32'd83886080;
            tune_gi = 32'd12;
            tune_gd = 32'd822083584;
            tune_base = 8'd75;
            tune_max = 8'd85;
            tune_min = 8'd65;
            tune_timeout = 16'd3000;
            tune_stop = 10'd7;
            integ = '0;
            prev_err = 0;
            heading = 0;
            marks = 3'd0;
            mark_seen = 1'b0;
            lifted = 1'b0;
            t_on_line = '0;
            t_partial = '0;
            wheel_l = SPD_STOP;
            wheel_r = SPD_STOP;
            expected_drive.delete();
            fails = 0;
            checked = 0;
            fail_count <= 0;
            outstanding <= 0;
            compared <= 0;
        end
        else begin
            // register writes
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GAIN_P:        tune_gp = cfg_data;
                    CFG_GAIN_I:        tune_gi = cfg_data;
                    CFG_GAIN_D:        tune_gd = cfg_data;
                    CFG_CRUISE_SPD:    tune_base = cfg_data[7:0];
                    CFG_TOP_SPD:       tune_max = cfg_data[7:0];
                    CFG_FLOOR_SPD:     tune_min = cfg_data[7:0];
                    CFG_TIMEOUT_MS:    tune_timeout = cfg_data[15:0];
                    CFG_STOP_DISTANCE: tune_stop = cfg_data[9:0];
                    default:           ;
                endcase
            end
            // output beat against oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_drive.size() == 0) begin
                    $display("%0t: output beat with no step pending, expected none, got %h",
                             $time, m_tdata);
                    fails++;
                end
                else begin
                    want = expected_drive.pop_front();
                    check_field("speed_left", want.left, m_tdata[7:0]);
                    check_field("speed_right", want.right, m_tdata[15:8]);
                    check_field("table_position", want.table_pos, m_tdata[18:16]);
                    check_field("halted", want.halted, m_tdata[19]);
                    check_field("tdata pad", 0, m_tdata[23:20]);
                end
                checked++;
            end
            // input beat: run the step
            if (s_tvalid && s_tready) begin
                advance_controller(s_tdata[4:0], s_tdata[14:5], s_tdata[46:15], next_drive);
                expected_drive.push_back(next_drive);
            end
            fail_count <= fails;
            outstanding <= expected_drive.size();
            compared <= checked;
        end
    end

endmodule

>>> verif/tb_line_follower_pid_steering.sv
// Testbench top for the steering block: drives control steps and tuning, gives the verdict.
`timescale 1ns / 100ps

module tb_line_follower_pid_steering;
    import lfps_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count, outstanding, compared;

    // Stimulus bookkeeping
    logic [31:0] clock_ms = 32'd7000;
    logic [31:0] last_part_sent = '0;
    int          cur_timeout = 3000;
    int          cur_stop = 7;
    int          burst_left = 0;
    int          steps_sent = 0;
    int          tunings = 1;

    // Receiver stall pattern state
    logic [7:0]  rx_phase = '0;
    logic [1:0]  rx_mode = '0;
    int          quiet_cycles = 0;

    line_follower_pid_steering DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    steering_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .compared    (compared)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: mode redrawn whenever rx_phase[5:0] wraps (always ready, coin flip, 3 of 4, long stalls)
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_phase[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 1) == 0);
            2'd2:    m_tready <= (rx_phase[1:0] != 2'd0);
            default: m_tready <= (rx_phase[3:0] == 4'd0);
        endcase
    end

    // Watchdog on cycles with no beat and no register write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no progress for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // One step beat; sender may idle between bursts of random length
    task automatic send_step(input logic [4:0] bits, input logic [9:0] range_cm,
                             input logic [31:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        if (range_cm >= cur_stop && bits != 5'b00000) last_part_sent = now;
        s_tdata <= {1'b0, now, range_cm, bits};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        steps_sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Drain the block, then retune all registers
    task automatic apply_tuning(input logic [31:0] gp, input logic [31:0] gi,
                                input logic [31:0] gd, input logic [7:0] base,
                                input logic [7:0] top_spd, input logic [7:0] low_spd,
                                input logic [15:0] tmo, input logic [9:0] stop_cm);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_CRUISE_SPD, {24'd0, base});
        write_reg(CFG_TOP_SPD, {24'd0, top_spd});
        write_reg(CFG_FLOOR_SPD, {24'd0, low_spd});
        write_reg(CFG_TIMEOUT_MS, {16'd0, tmo});
        write_reg(CFG_STOP_DISTANCE, {22'd0, stop_cm});
        cfg_we <= 1'b0;
        cur_timeout = tmo;
        cur_stop = stop_cm;
        burst_left = 0;
        tunings++;
    endtask

    // Random driving: mostly track runs, lost-line spells and mark spells, some obstacle and noise steps
    task automatic run_traffic(input int n);
        int         done_items, kind, len, j;
        logic [4:0] bits;
        logic [9:0] range_cm;
        done_items = 0;
        while (done_items < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40) len = $urandom_range(3, 12);
            else if (kind < 60) len = $urandom_range(2, 8);
            else if (kind < 78) len = $urandom_range(1, 6);
            else if (kind < 88) len = $urandom_range(1, 3);
            else len = $urandom_range(1, 5);
            for (j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 9) == 0) range_cm = 10'($urandom);
                else range_cm = 10'($urandom_range(cur_stop, 1023));
                if (kind < 40)
                begin
                    bits = 5'($urandom_range(1, 30));
                    clock_ms += 32'($urandom_range(0, 20));
                end
                else if (kind < 60)
                begin
                    bits = 5'b11111;
                    clock_ms += 32'($urandom_range(0, cur_timeout / 3 + 2));
                end
                else if (kind < 78)
                begin
                    bits = 5'b00000;
                    // sometimes jump back near the last partial step (wrapped elapsed time)
                    if ($urandom_range(0, 5) == 0)
                        clock_ms = last_part_sent + 32'($urandom_range(0, cur_timeout));
                    else
                        clock_ms += 32'($urandom_range(0, cur_timeout / 3 + 2));
                end
                else if (kind < 88)
                begin
                    bits = 5'($urandom);
                    if (cur_stop > 0) range_cm = 10'($urandom_range(0, cur_stop - 1));
                    clock_ms += 32'($urandom_range(0, 20));
                end
                else
                begin
                    bits = 5'($urandom);
                    range_cm = 10'($urandom);
                    if ($urandom_range(0, 3) == 0) clock_ms += $urandom;
                    else clock_ms += 32'($urandom_range(0, 50));
                end
                send_step(bits, range_cm, clock_ms);
                done_items++;
            end
        end
    endtask

    initial
    begin
        int k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed steps at reset tuning
        send_step(5'b11011, 10'd1023, 32'd100);    // center sensor only, zero error
        send_step(5'b11110, 10'd7, 32'd110);       // far left, distance at threshold
        send_step(5'b01111, 10'd500, 32'd120);     // far right
        send_step(5'b00111, 10'd300, 32'd130);     // largest right sum
        send_step(5'b11100, 10'd300, 32'd140);     // largest left sum
        send_step(5'b11011, 10'd0, 32'd150);       // obstacle at zero distance
        send_step(5'b11111, 10'd300, 32'd170);     // line lost, recovery from left heading
        send_step(5'b11111, 10'd300, 32'd3140);    // lost exactly at timeout
        send_step(5'b11111, 10'd300, 32'd3150);    // heading cleared
        send_step(5'b10111, 10'd300, 32'd3160);
        send_step(5'b00000, 10'd300, 32'd3170);    // mark counted
        send_step(5'b00000, 10'd300, 32'd3180);    // mark held, no recount
        send_step(5'b00000, 10'd300, 32'd6160);    // lift-off
        send_step(5'b00000, 10'd300, 32'd3165);    // lifted, elapsed below timeout: speeds held
        send_step(5'b01110, 10'd300, 32'd6200);    // back on line clears lift
        for (k = 0; k < 6; k++)
        begin
            // table count wraps past six
            send_step(5'b00000, 10'd300, 32'd6210 + 32'(20 * k));
            send_step(5'b11101, 10'd300, 32'd6220 + 32'(20 * k));
        end
        run_traffic(80);

        apply_tuning(32'h0200_0000, 32'h0000_4000, 32'h0A00_0000,
                     8'd128, 8'd200, 8'd40, 16'd40, 10'd20);
        run_traffic(80);

        // extremes: full gains, widest clamp, zero timeout, no obstacle stop
        apply_tuning(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     8'd255, 8'd255, 8'd0, 16'd0, 10'd0);
        run_traffic(80);

        // zero gains, inverted clamp, longest timeout, widest stop range
        apply_tuning(32'd0, 32'd0, 32'd0, 8'd0, 8'd0, 8'd255, 16'hFFFF, 10'd1023);
        run_traffic(80);

        apply_tuning($urandom, $urandom, $urandom, 8'($urandom), 8'($urandom),
                     8'($urandom), 16'($urandom_range(1, 200)), 10'($urandom_range(0, 60)));
        run_traffic(80);

        // drain and settle
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Drove %0d control steps under %0d tunings; %0d output beats checked.",
                 steps_sent, tunings, compared);
        $display("Covered track, lost-line, mark, lift-off, obstacle and noise steps.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
